// ===== design/sprt_pkg.sv =====
`default_nettype none
package sprt_pkg;

    // verdict codes
    localparam logic [1:0] VERDICT_CONTINUE = 2'd0;
    localparam logic [1:0] VERDICT_UPPER    = 2'd1;
    localparam logic [1:0] VERDICT_LOWER    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_TEST_ENABLED = 3'd0;
    localparam logic [2:0] REG_SCORE_NULL   = 3'd1;
    localparam logic [2:0] REG_SCORE_ALT    = 3'd2;
    localparam logic [2:0] REG_BOUND_LOWER  = 3'd3;
    localparam logic [2:0] REG_BOUND_UPPER  = 3'd4;

    localparam int CFG_DATA_BITS = 32;
    localparam int SCORE_BITS    = 16;
    localparam int RATIO_BITS    = 32;

    // request classification made by the front end
    typedef struct packed {
        logic enabled;   // test was enabled at accept
        logic any_zero;  // some count is zero: ratio forced to 0
    } sprt_flags_t;

    // live configuration handed to the back end
    typedef struct packed {
        logic [SCORE_BITS-1:0]        score_null;
        logic [SCORE_BITS-1:0]        score_alt;
        logic signed [RATIO_BITS-1:0] bound_lower;
        logic signed [RATIO_BITS-1:0] bound_upper;
    } sprt_cfg_t;

endpackage
`default_nettype wire

// ===== design/sprt_front.sv =====
`default_nettype none
module sprt_front
    import sprt_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic                     stall,
    input  wire logic [COUNT_BITS-1:0]    wins,
    input  wire logic [COUNT_BITS-1:0]    draws,
    input  wire logic [COUNT_BITS-1:0]    losses,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                          req_valid,
    output logic [3*COUNT_BITS-1:0]       req_counts,
    output sprt_flags_t                   req_flags,
    output sprt_cfg_t                     cfg
);

    logic              enabled_reg;
    sprt_cfg_t         cfg_reg;
    logic              valid_reg;
    logic [3*COUNT_BITS-1:0] counts_reg;
    sprt_flags_t       flags_reg;
    logic              accept;

    assign accept = start && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg         <= 1'b0;
            cfg_reg.score_null  <= SCORE_BITS'(32768);
            cfg_reg.score_alt   <= SCORE_BITS'(32768);
            cfg_reg.bound_lower <= '0;
            cfg_reg.bound_upper <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TEST_ENABLED: enabled_reg         <= cfg_data[0];
                REG_SCORE_NULL:   cfg_reg.score_null  <= cfg_data[SCORE_BITS-1:0];
                REG_SCORE_ALT:    cfg_reg.score_alt   <= cfg_data[SCORE_BITS-1:0];
                REG_BOUND_LOWER:  cfg_reg.bound_lower <= cfg_data;
                REG_BOUND_UPPER:  cfg_reg.bound_upper <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            counts_reg         <= {wins, draws, losses};
            flags_reg.enabled  <= enabled_reg;
            flags_reg.any_zero <= (wins == '0) || (draws == '0) || (losses == '0);
        end
    end

    assign req_valid  = valid_reg;
    assign req_counts = counts_reg;
    assign req_flags  = flags_reg;
    assign cfg        = cfg_reg;

endmodule
`default_nettype wire

// ===== design/sprt_fifo.sv =====
`default_nettype none
module sprt_fifo
    import sprt_pkg::*;
#(
    parameter int WIDTH = 62
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic                  full,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wptr_reg;
    logic             rptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign not_empty = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign do_pop    = pop && not_empty;
    assign do_push   = push && !full;
    assign pop_data  = mem_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            count_reg <= count_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

// ===== design/sprt_back.sv =====
`default_nettype none
module sprt_back
    import sprt_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic [3*COUNT_BITS-1:0] in_counts,
    input  wire sprt_flags_t            in_flags,
    input  wire sprt_cfg_t              cfg,
    output logic                        done,
    output logic signed [RATIO_BITS-1:0] log_ratio,
    output logic [1:0]                  verdict
);

    localparam int C    = COUNT_BITS;
    localparam int N    = C + 2;
    localparam int P    = C + 18;
    localparam int M    = C + 19;
    localparam int X    = M + SCORE_BITS;
    localparam int N2   = 2 * N;
    localparam int D    = 2 * C + 18;
    localparam int NUMW = X + N2;
    localparam int XL   = X / 2;
    localparam int XH   = X - XL;
    localparam int NL   = N2 / 2;
    localparam int NH   = N2 - NL;
    localparam int QB   = RATIO_BITS - 1;
    localparam int RW   = (NUMW > D + QB) ? NUMW : D + QB;

    logic [C-1:0] w_in, d_in, l_in;
    logic [N-1:0] n_c;
    assign w_in = in_counts[3*C-1:2*C];
    assign d_in = in_counts[2*C-1:C];
    assign l_in = in_counts[C-1:0];
    assign n_c  = N'(w_in) + N'(d_in) + N'(l_in);

    // stage 1: sums and narrow products
    logic              v1_reg;
    sprt_flags_t       f1_reg;
    logic [N-1:0]      n1_reg;
    logic [P-1:0]      p1_reg;
    logic [M-1:0]      m1_reg;
    logic [SCORE_BITS-1:0] dmag1_reg;
    logic              dneg1_reg;
    logic [2*C-1:0]    wd1_reg, wl1_reg, dl1_reg;
    logic [SCORE_BITS:0] ssum;
    assign ssum = (SCORE_BITS+1)'(cfg.score_null) + (SCORE_BITS+1)'(cfg.score_alt);

    always_ff @(posedge clk)
    begin
        f1_reg    <= in_flags;
        n1_reg    <= n_c;
        p1_reg    <= {N'({w_in, 1'b0}) + N'(d_in), 16'b0};
        m1_reg    <= M'(n_c) * M'(ssum);
        dneg1_reg <= cfg.score_alt < cfg.score_null;
        dmag1_reg <= (cfg.score_alt >= cfg.score_null) ? cfg.score_alt - cfg.score_null
                                                      : cfg.score_null - cfg.score_alt;
        wd1_reg   <= (2*C)'(w_in) * (2*C)'(d_in);
        wl1_reg   <= (2*C)'(w_in) * (2*C)'(l_in);
        dl1_reg   <= (2*C)'(d_in) * (2*C)'(l_in);
    end

    // stage 2: term magnitude, denominator, n squared
    sprt_flags_t       f2_reg;
    logic [M-1:0]      tmag2_reg;
    logic              neg2_reg;
    logic [SCORE_BITS-1:0] dmag2_reg;
    logic [D-1:0]      den2_reg;
    logic [N2-1:0]     nsq2_reg;
    logic [M-1:0]      pe;
    assign pe = M'(p1_reg);

    always_ff @(posedge clk)
    begin
        f2_reg    <= f1_reg;
        tmag2_reg <= (pe >= m1_reg) ? pe - m1_reg : m1_reg - pe;
        neg2_reg  <= dneg1_reg ^ (pe < m1_reg);
        dmag2_reg <= dmag1_reg;
        den2_reg  <= (D'(wd1_reg) + (D'(wl1_reg) << 2) + D'(dl1_reg)) << 15;
        nsq2_reg  <= N2'(n1_reg) * N2'(n1_reg);
    end

    // stage 3: score difference times term
    sprt_flags_t       f3_reg;
    logic              neg3_reg;
    logic [X-1:0]      x3_reg;
    logic [D-1:0]      den3_reg;
    logic [N2-1:0]     nsq3_reg;

    always_ff @(posedge clk)
    begin
        f3_reg   <= f2_reg;
        neg3_reg <= neg2_reg;
        x3_reg   <= X'(dmag2_reg) * X'(tmag2_reg);
        den3_reg <= den2_reg;
        nsq3_reg <= nsq2_reg;
    end

    // stage 4: partial products of x * n^2
    sprt_flags_t       f4_reg;
    logic              neg4_reg;
    logic [D-1:0]      den4_reg;
    logic [XL+NL-1:0]  pp0_reg;
    logic [XL+NH-1:0]  pp1_reg;
    logic [XH+NL-1:0]  pp2_reg;
    logic [XH+NH-1:0]  pp3_reg;

    always_ff @(posedge clk)
    begin
        f4_reg   <= f3_reg;
        neg4_reg <= neg3_reg;
        den4_reg <= den3_reg;
        pp0_reg  <= (XL+NL)'(x3_reg[XL-1:0]) * (XL+NL)'(nsq3_reg[NL-1:0]);
        pp1_reg  <= (XL+NH)'(x3_reg[XL-1:0]) * (XL+NH)'(nsq3_reg[N2-1:NL]);
        pp2_reg  <= (XH+NL)'(x3_reg[X-1:XL]) * (XH+NL)'(nsq3_reg[NL-1:0]);
        pp3_reg  <= (XH+NH)'(x3_reg[X-1:XL]) * (XH+NH)'(nsq3_reg[N2-1:NL]);
    end

    // stage 5: numerator
    sprt_flags_t       f5_reg;
    logic              neg5_reg;
    logic [D-1:0]      den5_reg;
    logic [NUMW-1:0]   num5_reg;

    always_ff @(posedge clk)
    begin
        f5_reg   <= f4_reg;
        neg5_reg <= neg4_reg;
        den5_reg <= den4_reg;
        num5_reg <= NUMW'(pp0_reg) + (NUMW'(pp1_reg) << NL) + (NUMW'(pp2_reg) << XL)
                    + (NUMW'(pp3_reg) << (XL + NL));
    end

    // divider: stage 0 checks overflow, stages 1..QB each restore one quotient bit
    sprt_flags_t       fd_reg   [0:QB];
    logic              negd_reg [0:QB];
    logic              ovf_reg  [0:QB];
    logic [D-1:0]      dend_reg [0:QB];
    logic [RW-1:0]     rem_reg  [0:QB];
    logic [QB-1:0]     q_reg    [0:QB];

    always_ff @(posedge clk)
    begin
        fd_reg[0]   <= f5_reg;
        negd_reg[0] <= neg5_reg;
        dend_reg[0] <= den5_reg;
        rem_reg[0]  <= RW'(num5_reg);
        ovf_reg[0]  <= RW'(num5_reg) >= (RW'(den5_reg) << QB);
        q_reg[0]    <= '0;
    end

    for (genvar j = 1; j <= QB; j++)
    begin : g_div
        localparam int K = QB - j;
        logic [RW-1:0] trial;
        logic          fits;
        assign trial = RW'(dend_reg[j-1]) << K;
        assign fits  = rem_reg[j-1] >= trial;

        always_ff @(posedge clk)
        begin
            fd_reg[j]   <= fd_reg[j-1];
            negd_reg[j] <= negd_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
            dend_reg[j] <= dend_reg[j-1];
            rem_reg[j]  <= fits ? rem_reg[j-1] - trial : rem_reg[j-1];
            q_reg[j]    <= q_reg[j-1] | (fits ? (QB'(1) << K) : '0);
        end
    end

    // sign and saturation
    logic              vs_reg;
    logic              ens_reg;
    logic signed [RATIO_BITS-1:0] rs_reg;
    logic signed [RATIO_BITS-1:0] r_c;
    sprt_flags_t       ff;
    logic [QB-1:0]     qf;
    assign ff = fd_reg[QB];
    assign qf = q_reg[QB];

    always_comb
    begin
        if (!ff.enabled || ff.any_zero || (!ovf_reg[QB] && qf == '0))
            r_c = '0;
        else if (negd_reg[QB])
            r_c = ovf_reg[QB] ? {1'b1, {QB{1'b0}}} : -{1'b0, qf};
        else
            r_c = ovf_reg[QB] ? {1'b0, {QB{1'b1}}} : {1'b0, qf};
    end

    always_ff @(posedge clk)
    begin
        rs_reg  <= r_c;
        ens_reg <= ff.enabled;
    end

    // verdict against the bounds
    logic              vo_reg;
    logic signed [RATIO_BITS-1:0] ro_reg;
    logic [1:0]        vd_reg;

    always_ff @(posedge clk)
    begin
        ro_reg <= rs_reg;
        if (ens_reg && rs_reg > cfg.bound_upper)
            vd_reg <= VERDICT_UPPER;
        else if (ens_reg && rs_reg < cfg.bound_lower)
            vd_reg <= VERDICT_LOWER;
        else
            vd_reg <= VERDICT_CONTINUE;
    end

    // valid chain
    logic [QB:0] vd_chain_reg;
    logic v2_reg, v3_reg, v4_reg, v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            vd_chain_reg <= '0;
            vs_reg       <= 1'b0;
            vo_reg       <= 1'b0;
        end
        else
        begin
            v1_reg       <= in_valid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            v5_reg       <= v4_reg;
            vd_chain_reg <= {vd_chain_reg[QB-1:0], v5_reg};
            vs_reg       <= vd_chain_reg[QB];
            vo_reg       <= vs_reg;
        end
    end

    assign done      = vo_reg;
    assign log_ratio = ro_reg;
    assign verdict   = vd_reg;

endmodule
`default_nettype wire

// ===== design/sprt_llr_decision_top.sv =====
// Trinomial SPRT log-likelihood ratio and verdict.
// Throughput: one request per cycle; multipliers and the 31-stage restoring
// divider are fully pipelined, a two-entry queue parts front end and back end.
// Reset: async active low; clears control state and loads register defaults.
// The receiver cannot stall: done is a one-cycle strobe.
`default_nettype none
module sprt_llr_decision_top
    import sprt_pkg::*;
#(
    parameter int COUNT_BITS = 20
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [COUNT_BITS-1:0]    wins,
    input  wire logic [COUNT_BITS-1:0]    draws,
    input  wire logic [COUNT_BITS-1:0]    losses,
    input  wire logic                     cfg_we,
    input  wire logic [2:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output logic                          done,
    output logic signed [RATIO_BITS-1:0]  log_ratio,
    output logic [1:0]                    verdict
);

    localparam int QW = 3 * COUNT_BITS + $bits(sprt_flags_t);

    logic                      req_valid;
    logic [3*COUNT_BITS-1:0]   req_counts;
    sprt_flags_t               req_flags;
    sprt_cfg_t                 cfg;
    logic                      q_not_empty;
    logic                      q_full;
    logic [QW-1:0]             q_data;

    // front end: register file, request capture, classification
    sprt_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .stall      (busy),
        .wins       (wins),
        .draws      (draws),
        .losses     (losses),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_counts (req_counts),
        .req_flags  (req_flags),
        .cfg        (cfg)
    );

    // queue between the two halves; the back end drains it every cycle
    sprt_fifo #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid),
        .push_data ({req_flags, req_counts}),
        .pop       (1'b1),
        .not_empty (q_not_empty),
        .full      (q_full),
        .pop_data  (q_data)
    );

    assign busy = q_full;

    // back end: ratio arithmetic, divider, saturation and verdict
    sprt_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_not_empty),
        .in_counts (q_data[3*COUNT_BITS-1:0]),
        .in_flags  (sprt_flags_t'(q_data[QW-1:3*COUNT_BITS])),
        .cfg       (cfg),
        .done      (done),
        .log_ratio (log_ratio),
        .verdict   (verdict)
    );

endmodule
`default_nettype wire
